>>> hdl/mlr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared types and constants for the midpoint line rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

    localparam int COORD_BITS = 12;
    localparam int DEC_BITS   = COORD_BITS + 4;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [COORD_BITS-1:0] t_dist;
    typedef logic        [DEC_BITS-1:0]   t_dec;

    localparam t_coord COORD_ONE = t_coord'(1);

    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_ADVANCE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_SHALLOW = 2'd0,
        MODE_STEEP   = 2'd1,
        MODE_VERT    = 2'd2
    } t_mode;

    typedef struct packed {
        t_cmd   cmd;
        t_coord xa;
        t_coord ya;
        t_coord xb;
        t_coord yb;
    } t_in_req;

    typedef struct packed {
        t_coord px;
        t_coord py;
        logic   last;
    } t_out_req;

    // Classified request handed from the front to the back
    typedef struct packed {
        logic   is_start;
        t_coord x0;
        t_coord y0;
        t_dist  dx;
        t_dist  dya;
        logic   y_neg;
        t_mode  mode;
        t_dec   dec;
    } t_job;

endpackage
`default_nettype wire

>>> hdl/mlr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlr_front
// Takes requests, orders endpoints by x, and works out deltas, line mode and
// the initial doubled decision value.
// ----------------------------------------------------------------------------
module mlr_front import mlr_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_in_req i_req,
    output logic         o_stall,
    output logic         o_job_valid,
    output t_job         o_job,
    input  wire logic    i_q_full
);

    logic                  r_valid;
    t_job                  r_job;
    t_job                  n_job;
    logic                  w_swap;
    t_coord                w_x0;
    t_coord                w_y0;
    t_coord                w_x1;
    t_coord                w_y1;
    logic [COORD_BITS:0]   w_dx_full;
    logic [COORD_BITS:0]   w_dy_full;
    logic [COORD_BITS:0]   w_dy_neg;
    t_dist                 w_dx;
    t_dist                 w_dya;
    logic                  w_take;

    assign o_stall     = r_valid && i_q_full;
    assign w_take      = i_valid && !o_stall;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    always_comb begin
        // equal x keeps the first endpoint as the start
        w_swap    = $signed(i_req.xa) > $signed(i_req.xb);
        w_x0      = w_swap ? i_req.xb : i_req.xa;
        w_y0      = w_swap ? i_req.yb : i_req.ya;
        w_x1      = w_swap ? i_req.xa : i_req.xb;
        w_y1      = w_swap ? i_req.ya : i_req.yb;
        w_dx_full = {w_x1[COORD_BITS-1], w_x1} - {w_x0[COORD_BITS-1], w_x0};
        w_dy_full = {w_y1[COORD_BITS-1], w_y1} - {w_y0[COORD_BITS-1], w_y0};
        w_dy_neg  = -w_dy_full;
        w_dx      = w_dx_full[COORD_BITS-1:0];
        w_dya     = w_dy_full[COORD_BITS] ? w_dy_neg[COORD_BITS-1:0]
                                          : w_dy_full[COORD_BITS-1:0];

        n_job          = '0;
        n_job.is_start = (i_req.cmd == CMD_START);
        n_job.x0       = w_x0;
        n_job.y0       = w_y0;
        n_job.dx       = w_dx;
        n_job.dya      = w_dya;
        n_job.y_neg    = w_dy_full[COORD_BITS];
        if (w_dx == '0) begin
            n_job.mode = MODE_VERT;
            n_job.dec  = '0;
        end else if (w_dya <= w_dx) begin
            n_job.mode = MODE_SHALLOW;
            n_job.dec  = {3'b000, w_dya, 1'b0} - {4'b0000, w_dx};
        end else begin
            n_job.mode = MODE_STEEP;
            n_job.dec  = {3'b000, w_dx, 1'b0} - {4'b0000, w_dya};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (w_take) begin
            r_job <= n_job;
        end
    end

endmodule
`default_nettype wire

>>> hdl/mlr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlr_queue
// Short register queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module mlr_queue import mlr_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule
`default_nettype wire

>>> hdl/mlr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlr_back
// Line walker: holds the current pixel and decision value, steps one pixel
// per request, and drives the output register.
// ----------------------------------------------------------------------------
module mlr_back import mlr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  wire t_job i_job,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_req  o_res,
    input  wire logic i_stall
);

    logic     r_active;
    t_dist    r_left;
    t_coord   r_x;
    t_coord   r_y;
    t_dec     r_dec;
    t_dist    r_dx;
    t_dist    r_dya;
    logic     r_y_neg;
    t_mode    r_mode;
    logic     r_o_valid;
    t_out_req r_out;

    logic     n_active;
    t_dist    n_left;
    t_coord   n_x;
    t_coord   n_y;
    t_dec     n_dec;
    logic     w_take;
    logic     w_emit;
    logic     w_pos;
    t_coord   w_y_step;
    t_dist    w_steps;
    t_dec     w_two_dx;
    t_dec     w_two_dya;

    assign w_take    = i_q_valid && (!r_o_valid || !i_stall);
    assign o_pop     = w_take;
    assign o_valid   = r_o_valid;
    assign o_res     = r_out;
    assign w_pos     = !r_dec[DEC_BITS-1] && (r_dec != '0);
    assign w_y_step  = r_y_neg ? (r_y - COORD_ONE) : (r_y + COORD_ONE);
    assign w_two_dx  = {3'b000, r_dx, 1'b0};
    assign w_two_dya = {3'b000, r_dya, 1'b0};
    assign w_steps   = (i_job.mode == MODE_SHALLOW) ? i_job.dx : i_job.dya;

    always_comb begin
        n_active = r_active;
        n_left   = r_left;
        n_x      = r_x;
        n_y      = r_y;
        n_dec    = r_dec;
        w_emit   = 1'b0;
        if (i_job.is_start) begin
            n_x      = i_job.x0;
            n_y      = i_job.y0;
            n_dec    = i_job.dec;
            n_left   = w_steps;
            n_active = (w_steps != '0);
            w_emit   = 1'b1;
        end else if (r_active) begin
            case (r_mode)
                MODE_SHALLOW: begin
                    n_x   = r_x + COORD_ONE;
                    n_y   = w_pos ? w_y_step : r_y;
                    n_dec = r_dec + w_two_dya - (w_pos ? w_two_dx : '0);
                end
                MODE_STEEP: begin
                    n_x   = w_pos ? (r_x + COORD_ONE) : r_x;
                    n_y   = w_y_step;
                    n_dec = r_dec + w_two_dx - (w_pos ? w_two_dya : '0);
                end
                default: begin
                    n_y = w_y_step;
                end
            endcase
            n_left   = r_left - t_dist'(1);
            n_active = (n_left != '0);
            w_emit   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_left    <= '0;
            r_mode    <= MODE_SHALLOW;
            r_o_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_active <= n_active;
                r_left   <= n_left;
                if (i_job.is_start) begin
                    r_mode <= i_job.mode;
                end
            end
            if (!r_o_valid || !i_stall) begin
                r_o_valid <= w_take && w_emit;
            end
        end
        if (w_take) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_dec <= n_dec;
            if (i_job.is_start) begin
                r_dx    <= i_job.dx;
                r_dya   <= i_job.dya;
                r_y_neg <= i_job.y_neg;
            end
            if (w_emit) begin
                r_out.px   <= n_x;
                r_out.py   <= n_y;
                r_out.last <= !n_active;
            end
        end
    end

endmodule
`default_nettype wire

>>> hdl/midpoint_line_rasterizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// Midpoint line rasterizer: a start request emits the left endpoint, each
// advance request on an active line emits the next pixel, last on the final one.
//
//   channel  dir  handshake          payload
//   request  in   i_valid / o_stall  i_req (t_in_req)
//   pixel    out  o_valid / i_stall  o_res (t_out_req)
//
// One request per clock while the output is not stalled; a request passes the
// front register, the queue and the output register before its pixel leaves.
// The back walks the line with one add and compare on the decision value.
// Synchronous active-low reset clears the queue, the line and the output.
// Output stalls back up through the queue; the front stalls only when the
// queue is full.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer import mlr_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_in_req i_req,
    output logic         o_stall,
    output logic         o_valid,
    output t_out_req     o_res,
    input  wire logic    i_stall
);

    logic w_job_valid;
    t_job w_job;
    logic w_q_full;
    logic w_q_push;
    logic w_q_valid;
    t_job w_q_job;
    logic w_q_pop;

    assign w_q_push = w_job_valid && !w_q_full;

    mlr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_req       (i_req),
        .o_stall     (o_stall),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_q_full    (w_q_full)
    );

    mlr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_job),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    mlr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_job     (w_q_job),
        .o_pop     (w_q_pop),
        .o_valid   (o_valid),
        .o_res     (o_res),
        .i_stall   (i_stall)
    );

    // reset leaves no pixel pending and the input open
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output or stall active after reset");

    // back never takes from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("pop from empty queue");

    // front stalls only when it holds a request the full queue cannot take
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (w_job_valid && w_q_full && !w_q_push))
        else $error("stall without a full queue");

endmodule
`default_nettype wire
